>>> hw/rtl/bqge_pkg.sv
package bqge_pkg;

    localparam logic OP_POINT = 1'b0;
    localparam logic OP_AREA  = 1'b1;

    localparam int THR_W = 33;
    localparam logic [THR_W-1:0] THR_RESET = 33'd1;

    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;
    localparam logic [APB_ADDR_W-1:0] ADDR_THR = 4'h0;

    localparam logic signed [15:0] ONE_Q14   = 16'sd16384;
    localparam logic signed [15:0] GAUSS_Q14 = 16'sd9459;
    localparam logic signed [31:0] ONE_Q16   = 32'sd65536;

    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    // pipeline depths
    localparam int FRONT_LAT = 4;
    localparam int DET_LAT   = 6;
    localparam int DIV_STEPS = 33;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int PIPE_LAT  = FRONT_LAT + DET_LAT + DIV_LAT + 1;

    // jacobian lanes: r-derivatives vary with s, s-derivatives vary with r
    typedef struct packed {
        logic              op;
        logic signed [31:0] mapped_x;
        logic signed [31:0] mapped_y;
        logic signed [31:0] xr0;
        logic signed [31:0] xr1;
        logic signed [31:0] yr0;
        logic signed [31:0] yr1;
        logic signed [31:0] xs0;
        logic signed [31:0] xs1;
        logic signed [31:0] ys0;
        logic signed [31:0] ys1;
    } t_front;

    typedef struct packed {
        logic               op;
        logic signed [31:0] mapped_x;
        logic signed [31:0] mapped_y;
        logic signed [31:0] jac_xr;
        logic signed [31:0] jac_xs;
        logic signed [31:0] jac_yr;
        logic signed [31:0] jac_ys;
        logic signed [63:0] det;
        logic               singular;
    } t_byp;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > 66'(S32_MAX)) begin
            res = S32_MAX;
        end else if (v < 66'(S32_MIN)) begin
            res = S32_MIN;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] res;
        s = 65'(a) + 65'(b);
        if (s > 65'(S64_MAX)) begin
            res = S64_MAX;
        end else if (s < 65'(S64_MIN)) begin
            res = S64_MIN;
        end else begin
            res = s[63:0];
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/bqge_front.sv
module bqge_front (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic                i_op,
    input  logic [3:0][31:0]    i_nx,
    input  logic [3:0][31:0]    i_ny,
    input  logic signed [15:0]  i_r,
    input  logic signed [15:0]  i_s,
    output bqge_pkg::t_front    o_front
);

    typedef struct packed {
        logic signed [33:0] a;
        logic signed [33:0] b;
        logic signed [33:0] c;
        logic signed [33:0] d;
    } t_combo;

    function automatic t_combo combo(input logic [3:0][31:0] p);
        t_combo res;
        logic signed [33:0] p0, p1, p2, p3;
        p0 = 34'($signed(p[0]));
        p1 = 34'($signed(p[1]));
        p2 = 34'($signed(p[2]));
        p3 = 34'($signed(p[3]));
        res.a = p0 + p1 + p2 + p3;
        res.b = -p0 + p1 + p2 - p3;
        res.c = -p0 - p1 + p2 + p3;
        res.d = p0 - p1 + p2 - p3;
        return res;
    endfunction

    function automatic logic signed [15:0] clamp_q14(input logic signed [15:0] v);
        logic signed [15:0] res;
        if (v > bqge_pkg::ONE_Q14) begin
            res = bqge_pkg::ONE_Q14;
        end else if (v < -bqge_pkg::ONE_Q14) begin
            res = -bqge_pkg::ONE_Q14;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // stage 1
    logic signed [15:0] w_r, w_s;
    logic signed [29:0] w_rs;
    logic signed [15:0] w_rl0, w_sl0;
    t_combo             w_cx, w_cy;

    logic               r1_op;
    t_combo             r1_cx, r1_cy;
    logic signed [15:0] r1_r, r1_s;
    logic signed [29:0] r1_rs;
    logic signed [15:0] r1_rl[2];
    logic signed [15:0] r1_sl[2];

    always_comb begin
        w_r   = clamp_q14(i_r);
        w_s   = clamp_q14(i_s);
        w_rs  = 30'(32'(w_r) * 32'(w_s));
        w_cx  = combo(i_nx);
        w_cy  = combo(i_ny);
        // area mode evaluates at the gauss points, lane 0 is the minus side
        w_rl0 = (i_op == bqge_pkg::OP_AREA) ? -bqge_pkg::GAUSS_Q14 : w_r;
        w_sl0 = (i_op == bqge_pkg::OP_AREA) ? -bqge_pkg::GAUSS_Q14 : w_s;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op    <= i_op;
            r1_cx    <= w_cx;
            r1_cy    <= w_cy;
            r1_r     <= w_r;
            r1_s     <= w_s;
            r1_rs    <= w_rs;
            r1_rl[0] <= w_rl0;
            r1_rl[1] <= bqge_pkg::GAUSS_Q14;
            r1_sl[0] <= w_sl0;
            r1_sl[1] <= bqge_pkg::GAUSS_Q14;
        end
    end

    // stage 2: products
    logic               r2_op;
    logic signed [33:0] r2_ax, r2_ay, r2_bx, r2_by, r2_cx, r2_cy;
    logic signed [49:0] r2_brx, r2_bry, r2_csx, r2_csy;
    logic signed [63:0] r2_drsx, r2_drsy;
    logic signed [49:0] r2_tsx[2];
    logic signed [49:0] r2_tsy[2];
    logic signed [49:0] r2_trx[2];
    logic signed [49:0] r2_try[2];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_op   <= r1_op;
            r2_ax   <= r1_cx.a;
            r2_ay   <= r1_cy.a;
            r2_bx   <= r1_cx.b;
            r2_by   <= r1_cy.b;
            r2_cx   <= r1_cx.c;
            r2_cy   <= r1_cy.c;
            r2_brx  <= 50'(r1_cx.b) * 50'(r1_r);
            r2_bry  <= 50'(r1_cy.b) * 50'(r1_r);
            r2_csx  <= 50'(r1_cx.c) * 50'(r1_s);
            r2_csy  <= 50'(r1_cy.c) * 50'(r1_s);
            r2_drsx <= 64'(r1_cx.d) * 64'(r1_rs);
            r2_drsy <= 64'(r1_cy.d) * 64'(r1_rs);
            for (int k = 0; k < 2; k++) begin
                r2_tsx[k] <= 50'(r1_cx.d) * 50'(r1_sl[k]);
                r2_tsy[k] <= 50'(r1_cy.d) * 50'(r1_sl[k]);
                r2_trx[k] <= 50'(r1_cx.d) * 50'(r1_rl[k]);
                r2_try[k] <= 50'(r1_cy.d) * 50'(r1_rl[k]);
            end
        end
    end

    // stage 3: exact sums
    logic               r3_op;
    logic signed [65:0] r3_ux, r3_uy;
    logic signed [50:0] r3_vxr[2];
    logic signed [50:0] r3_vyr[2];
    logic signed [50:0] r3_vxs[2];
    logic signed [50:0] r3_vys[2];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_op <= r2_op;
            r3_ux <= (66'(r2_ax) <<< 28) + (66'(r2_brx) <<< 14) + (66'(r2_csx) <<< 14)
                     + 66'(r2_drsx);
            r3_uy <= (66'(r2_ay) <<< 28) + (66'(r2_bry) <<< 14) + (66'(r2_csy) <<< 14)
                     + 66'(r2_drsy);
            for (int k = 0; k < 2; k++) begin
                r3_vxr[k] <= (51'(r2_bx) <<< 14) + 51'(r2_tsx[k]);
                r3_vyr[k] <= (51'(r2_by) <<< 14) + 51'(r2_tsy[k]);
                r3_vxs[k] <= (51'(r2_cx) <<< 14) + 51'(r2_trx[k]);
                r3_vys[k] <= (51'(r2_cy) <<< 14) + 51'(r2_try[k]);
            end
        end
    end

    // stage 4: round half up, saturate
    function automatic logic signed [31:0] rnd16(input logic signed [50:0] v);
        logic signed [50:0] t;
        t = (v + 51'sd32768) >>> 16;
        return bqge_pkg::sat32(66'(t));
    endfunction

    function automatic logic signed [31:0] rnd30(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = (v + 66'sd536870912) >>> 30;
        return bqge_pkg::sat32(t);
    endfunction

    bqge_pkg::t_front r4_front;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_front.op       <= r3_op;
            r4_front.mapped_x <= rnd30(r3_ux);
            r4_front.mapped_y <= rnd30(r3_uy);
            r4_front.xr0      <= rnd16(r3_vxr[0]);
            r4_front.xr1      <= rnd16(r3_vxr[1]);
            r4_front.yr0      <= rnd16(r3_vyr[0]);
            r4_front.yr1      <= rnd16(r3_vyr[1]);
            r4_front.xs0      <= rnd16(r3_vxs[0]);
            r4_front.xs1      <= rnd16(r3_vxs[1]);
            r4_front.ys0      <= rnd16(r3_vys[0]);
            r4_front.ys1      <= rnd16(r3_vys[1]);
        end
    end

    assign o_front = r4_front;

endmodule

>>> hw/rtl/bqge_det.sv
module bqge_det (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  bqge_pkg::t_front              i_front,
    input  logic [bqge_pkg::THR_W-1:0]    i_thr,
    output bqge_pkg::t_byp                o_byp
);

    bqge_pkg::t_byp     w_carry;

    // det index 2*p+q: p picks the r lane, q the s lane
    logic signed [31:0] w_xr[2], w_yr[2], w_xs[2], w_ys[2];

    always_comb begin
        w_carry          = '0;
        w_carry.op       = i_front.op;
        w_carry.mapped_x = i_front.mapped_x;
        w_carry.mapped_y = i_front.mapped_y;
        w_carry.jac_xr   = i_front.xr0;
        w_carry.jac_xs   = i_front.xs0;
        w_carry.jac_yr   = i_front.yr0;
        w_carry.jac_ys   = i_front.ys0;
        w_xr[0] = i_front.xr0;
        w_xr[1] = i_front.xr1;
        w_yr[0] = i_front.yr0;
        w_yr[1] = i_front.yr1;
        w_xs[0] = i_front.xs0;
        w_xs[1] = i_front.xs1;
        w_ys[0] = i_front.ys0;
        w_ys[1] = i_front.ys1;
    end

    // stage 5: products
    logic signed [63:0] r5_p0[4];
    logic signed [63:0] r5_p1[4];
    bqge_pkg::t_byp     r5_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_c <= w_carry;
            for (int p = 0; p < 2; p++) begin
                for (int q = 0; q < 2; q++) begin
                    r5_p0[2*p+q] <= 64'(w_xr[q]) * 64'(w_ys[p]);
                    r5_p1[2*p+q] <= 64'(w_xs[p]) * 64'(w_yr[q]);
                end
            end
        end
    end

    // stage 6: determinants
    logic signed [63:0] r6_det[4];
    bqge_pkg::t_byp     r6_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_c <= r5_c;
            for (int k = 0; k < 4; k++) begin
                r6_det[k] <= r5_p0[k] - r5_p1[k];
            end
        end
    end

    // stages 7 to 9: saturating sum in gauss order
    logic signed [63:0] r7_acc, r7_d0, r7_d2, r7_d3;
    bqge_pkg::t_byp     r7_c;
    logic signed [63:0] r8_acc, r8_d0, r8_d3;
    logic [63:0]        r8_mag;
    logic               r8_zero;
    bqge_pkg::t_byp     r8_c;
    logic signed [63:0] r9_acc, r9_d0;
    logic [63:0]        r9_mag;
    logic               r9_zero;
    bqge_pkg::t_byp     r9_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_acc  <= bqge_pkg::sat_add64(r6_det[0], r6_det[1]);
            r7_d0   <= r6_det[0];
            r7_d2   <= r6_det[2];
            r7_d3   <= r6_det[3];
            r7_c    <= r6_c;
            r8_acc  <= bqge_pkg::sat_add64(r7_acc, r7_d2);
            r8_d0   <= r7_d0;
            r8_d3   <= r7_d3;
            r8_mag  <= r7_d0[63] ? 64'(-r7_d0) : 64'(r7_d0);
            r8_zero <= (r7_d0 == 64'sd0);
            r8_c    <= r7_c;
            r9_acc  <= bqge_pkg::sat_add64(r8_acc, r8_d3);
            r9_d0   <= r8_d0;
            r9_mag  <= r8_mag;
            r9_zero <= r8_zero;
            r9_c    <= r8_c;
        end
    end

    // stage 10: absolute area, singular test
    logic signed [63:0] w_area;
    bqge_pkg::t_byp     w_out;
    bqge_pkg::t_byp     r10_out;

    always_comb begin
        if (!r9_acc[63]) begin
            w_area = r9_acc;
        end else if (r9_acc == bqge_pkg::S64_MIN) begin
            w_area = bqge_pkg::S64_MAX;
        end else begin
            w_area = -r9_acc;
        end
        w_out = r9_c;
        if (r9_c.op == bqge_pkg::OP_AREA) begin
            w_out.det      = w_area;
            w_out.singular = 1'b0;
        end else begin
            w_out.det      = r9_d0;
            w_out.singular = r9_zero || (r9_mag < 64'(i_thr));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r10_out <= w_out;
        end
    end

    assign o_byp = r10_out;

endmodule

>>> hw/rtl/bqge_div.sv
module bqge_div (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_num,
    input  logic signed [63:0] i_det,
    input  logic               i_neg,
    output logic signed [31:0] o_quo
);

    localparam int STEPS = bqge_pkg::DIV_STEPS;

    // setup: n = |num|*2^32 + |det|/2, quotient rounds to nearest
    logic [31:0] w_mn;
    logic [63:0] w_md, w_n;

    always_comb begin
        w_mn = i_num[31] ? 32'(-i_num) : 32'(i_num);
        w_md = i_det[63] ? 64'(-i_det) : 64'(i_det);
        w_n  = {w_mn, 32'd0} + (w_md >> 1);
    end

    logic [63:0]    r_rem[STEPS+1];
    logic [STEPS-1:0] r_nlo[STEPS+1];
    logic [STEPS-1:0] r_q[STEPS+1];
    logic [63:0]    r_md[STEPS+1];
    logic           r_ovf[STEPS+1];
    logic           r_neg[STEPS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= 64'(w_n[63:STEPS]);
            r_nlo[0] <= w_n[STEPS-1:0];
            r_q[0]   <= '0;
            r_md[0]  <= w_md;
            r_ovf[0] <= (64'(w_n[63:STEPS]) >= w_md);
            r_neg[0] <= i_neg ^ (i_num[31] ^ i_det[63]);
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [64:0] w_t;
        logic        w_ge;
        assign w_t  = {r_rem[k], r_nlo[k][STEPS-1]};
        assign w_ge = (w_t >= {1'b0, r_md[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= w_ge ? 64'(w_t - {1'b0, r_md[k]}) : w_t[63:0];
                r_nlo[k+1] <= r_nlo[k] << 1;
                r_q[k+1]   <= {r_q[k][STEPS-2:0], w_ge};
                r_md[k+1]  <= r_md[k];
                r_ovf[k+1] <= r_ovf[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    logic [STEPS-1:0]   w_q;
    logic signed [31:0] w_res;
    logic signed [31:0] r_res;

    always_comb begin
        w_q = r_q[STEPS];
        if (r_neg[STEPS]) begin
            if (r_ovf[STEPS] || (w_q > STEPS'(33'h080000000))) begin
                w_res = bqge_pkg::S32_MIN;
            end else begin
                w_res = 32'(-w_q);
            end
        end else begin
            if (r_ovf[STEPS] || (w_q > STEPS'(33'h07fffffff))) begin
                w_res = bqge_pkg::S32_MAX;
            end else begin
                w_res = w_q[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= w_res;
        end
    end

    assign o_quo = r_res;

endmodule

>>> hw/rtl/bilinear_quad_geometry_eval_top.sv
// channel   | valid          | stall          | payload
// ----------+----------------+----------------+---------------------------------
// request   | i_in_valid     | o_in_stall     | i_operation, i_node*_x/y, i_eval_r/s
// result    | o_out_valid    | i_out_stall    | o_mapped_*, o_jac_*, o_inv_*, o_singular
// config    | psel & penable | pready (high)  | paddr, pwdata, prdata
//
// one request per cycle while no stalled result holds the pipeline: 4 geometry stages,
// 6 determinant, 35 divider (one quotient bit per stage) stages and the output register
// synchronous active-low reset clears the valid chain and sets the threshold to 1
// a stalled result freezes the whole pipeline; o_in_stall is high only then
module bilinear_quad_geometry_eval_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_operation,
    input  logic signed [31:0]                 i_node0_x,
    input  logic signed [31:0]                 i_node0_y,
    input  logic signed [31:0]                 i_node1_x,
    input  logic signed [31:0]                 i_node1_y,
    input  logic signed [31:0]                 i_node2_x,
    input  logic signed [31:0]                 i_node2_y,
    input  logic signed [31:0]                 i_node3_x,
    input  logic signed [31:0]                 i_node3_y,
    input  logic signed [15:0]                 i_eval_r,
    input  logic signed [15:0]                 i_eval_s,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [31:0]                 o_mapped_x,
    output logic signed [31:0]                 o_mapped_y,
    output logic signed [31:0]                 o_jac_xr,
    output logic signed [31:0]                 o_jac_xs,
    output logic signed [31:0]                 o_jac_yr,
    output logic signed [31:0]                 o_jac_ys,
    output logic signed [63:0]                 o_jac_det,
    output logic signed [31:0]                 o_inv_rx,
    output logic signed [31:0]                 o_inv_ry,
    output logic signed [31:0]                 o_inv_sx,
    output logic signed [31:0]                 o_inv_sy,
    output logic                               o_singular,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bqge_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bqge_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bqge_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int LAT = bqge_pkg::PIPE_LAT;
    localparam int DL  = bqge_pkg::DIV_LAT;

    // config register
    logic [bqge_pkg::THR_W-1:0] r_thr;

    assign pready = 1'b1;
    assign prdata = (paddr == bqge_pkg::ADDR_THR) ? bqge_pkg::APB_DATA_W'(r_thr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= bqge_pkg::THR_RESET;
        end else if (psel && penable && pwrite && pready && paddr == bqge_pkg::ADDR_THR) begin
            r_thr <= pwdata[bqge_pkg::THR_W-1:0];
        end
    end

    // pipeline control
    logic           w_adv;
    logic [LAT-1:0] r_vld;

    assign w_adv      = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall = !w_adv;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // datapath
    bqge_pkg::t_front w_front;
    bqge_pkg::t_byp   w_byp;

    bqge_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_op    (i_operation),
        .i_nx    ({i_node3_x, i_node2_x, i_node1_x, i_node0_x}),
        .i_ny    ({i_node3_y, i_node2_y, i_node1_y, i_node0_y}),
        .i_r     (i_eval_r),
        .i_s     (i_eval_s),
        .o_front (w_front)
    );

    bqge_det u_det (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_front (w_front),
        .i_thr   (r_thr),
        .o_byp   (w_byp)
    );

    logic signed [31:0] w_q_rx, w_q_ry, w_q_sx, w_q_sy;

    bqge_div u_div_rx (
        .i_clk (i_clk), .i_en (w_adv), .i_num (w_byp.jac_ys), .i_det (w_byp.det),
        .i_neg (1'b0), .o_quo (w_q_rx)
    );
    bqge_div u_div_ry (
        .i_clk (i_clk), .i_en (w_adv), .i_num (w_byp.jac_xs), .i_det (w_byp.det),
        .i_neg (1'b1), .o_quo (w_q_ry)
    );
    bqge_div u_div_sx (
        .i_clk (i_clk), .i_en (w_adv), .i_num (w_byp.jac_yr), .i_det (w_byp.det),
        .i_neg (1'b1), .o_quo (w_q_sx)
    );
    bqge_div u_div_sy (
        .i_clk (i_clk), .i_en (w_adv), .i_num (w_byp.jac_xr), .i_det (w_byp.det),
        .i_neg (1'b0), .o_quo (w_q_sy)
    );

    // side fields wait alongside the dividers
    bqge_pkg::t_byp r_byp[DL];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_byp[0] <= w_byp;
            for (int k = 1; k < DL; k++) begin
                r_byp[k] <= r_byp[k-1];
            end
        end
    end

    // output register
    bqge_pkg::t_byp     w_tail;
    logic               r_op;
    logic signed [31:0] r_mx, r_my, r_jxr, r_jxs, r_jyr, r_jys;
    logic signed [63:0] r_det;
    logic signed [31:0] r_irx, r_iry, r_isx, r_isy;
    logic               r_sing;

    assign w_tail = r_byp[DL-1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_op  <= w_tail.op;
            r_det <= w_tail.det;
            if (w_tail.op == bqge_pkg::OP_AREA) begin
                r_mx   <= '0;
                r_my   <= '0;
                r_jxr  <= '0;
                r_jxs  <= '0;
                r_jyr  <= '0;
                r_jys  <= '0;
                r_irx  <= '0;
                r_iry  <= '0;
                r_isx  <= '0;
                r_isy  <= '0;
                r_sing <= 1'b0;
            end else begin
                r_mx   <= w_tail.mapped_x;
                r_my   <= w_tail.mapped_y;
                r_jxr  <= w_tail.jac_xr;
                r_jxs  <= w_tail.jac_xs;
                r_jyr  <= w_tail.jac_yr;
                r_jys  <= w_tail.jac_ys;
                r_sing <= w_tail.singular;
                if (w_tail.singular) begin
                    r_irx <= bqge_pkg::ONE_Q16;
                    r_iry <= '0;
                    r_isx <= '0;
                    r_isy <= bqge_pkg::ONE_Q16;
                end else begin
                    r_irx <= w_q_rx;
                    r_iry <= w_q_ry;
                    r_isx <= w_q_sx;
                    r_isy <= w_q_sy;
                end
            end
        end
    end

    assign o_mapped_x = r_mx;
    assign o_mapped_y = r_my;
    assign o_jac_xr   = r_jxr;
    assign o_jac_xs   = r_jxs;
    assign o_jac_yr   = r_jyr;
    assign o_jac_ys   = r_jys;
    assign o_jac_det  = r_det;
    assign o_inv_rx   = r_irx;
    assign o_inv_ry   = r_iry;
    assign o_inv_sx   = r_isx;
    assign o_inv_sy   = r_isy;
    assign o_singular = r_sing;

    // a frozen pipeline keeps every valid bit
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("valid chain moved while stalled");

    a_singular_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_singular |-> o_inv_rx == bqge_pkg::ONE_Q16 && o_inv_ry == 32'sd0
            && o_inv_sx == 32'sd0 && o_inv_sy == bqge_pkg::ONE_Q16)
        else $error("singular result without identity inverse");

    a_area_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_op == bqge_pkg::OP_AREA |-> !o_singular && o_mapped_x == 32'sd0
            && o_jac_xr == 32'sd0 && o_inv_rx == 32'sd0 && !o_jac_det[63])
        else $error("area result carries point fields or negative sum");

    a_nonzero_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_op == bqge_pkg::OP_POINT && !o_singular |-> o_jac_det != 64'sd0)
        else $error("zero determinant not flagged singular");

endmodule
